FILE: sv/dasc_pkg.sv
// dasc_pkg: shared types and constants of the debounced argmax class selector
// no dependencies; used by the interfaces, the lanes, the merge stage and the top level

package dasc_pkg;

   localparam int SCORE_W     = 16;    // width of a score field on the ports
   localparam int CLASS_W     = 3;     // width of a class index
   localparam int THRESH_W    = 8;     // width of a threshold and of an agree counter
   localparam int NUM_REGS    = 7;     // threshold registers, one per class
   localparam int CSR_IDX_W   = 3;     // register index width on the csr port
   localparam int CLASS_CAP   = 7;     // classes at this position or beyond are ignored

   localparam logic [CLASS_W-1:0]  POS_MAX      = 3'd7;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd5;

   // final argmax of both lanes at frame end
   typedef struct packed {
      logic [CLASS_W-1:0] primary_idx;
      logic [CLASS_W-1:0] rotated_idx;
   } frame_sum_type;

   // one result beat
   typedef struct packed {
      logic [CLASS_W-1:0] stable_class;
      logic [CLASS_W-1:0] candidate_class;
      logic               switched;
   } result_type;

   typedef logic [THRESH_W-1:0] thresh_array_type [NUM_REGS];

endpackage

FILE: sv/dasc_if.sv
// dasc_req_if / dasc_rsp_if: valid-ready channels of the selector
// depends on dasc_pkg for payload widths

interface dasc_req_if;
   logic                         valid;
   logic                         ready;
   logic [dasc_pkg::SCORE_W-1:0] primary_score;
   logic [dasc_pkg::SCORE_W-1:0] rotated_score;
   logic                         frame_last;

   modport source (output valid, primary_score, rotated_score, frame_last, input ready);
   modport sink   (input valid, primary_score, rotated_score, frame_last, output ready);
endinterface

interface dasc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dasc_pkg::CLASS_W-1:0] stable_class;
   logic [dasc_pkg::CLASS_W-1:0] candidate_class;
   logic                         switched;

   modport source (output valid, stable_class, candidate_class, switched, input ready);
   modport sink   (input valid, stable_class, candidate_class, switched, output ready);
endinterface

FILE: sv/debounced_argmax_class_selector_top.sv
// debounced_argmax_class_selector_top: two argmax lanes, merge stage and result register
// depends on dasc_pkg, dasc_if, dasc_argmax_lane and dasc_merge
//
// usage
// - req_bus carries one class per beat: the scores of both classifier views
//   and frame_last on the final class of a frame; classes arrive in order
// - each beat updates both running argmaxes in the cycle it is taken, so
//   req_bus takes one beat per cycle while nothing backs up
// - a frame_last beat produces one rsp_bus beat (stable class, candidate,
//   switched); other beats produce none
// - a frame_last beat loads the frame summary register; the merge then moves
//   its result into the result register, which drives rsp_bus
// - when the receiver stalls, the result waits in the result register and
//   the frame summary register still frees it for one more frame end; beats
//   keep flowing until both are full, then req_bus.ready drops
// - csr port writes a class threshold (index 0..6); other indexes are
//   dropped; write only while the block is idle
// - reset (synchronous, active high) clears the argmaxes, class position,
//   candidate, stable class, agree counters and switched, and sets every
//   threshold to 5

module debounced_argmax_class_selector_top #(
   parameter int NUM_CLASSES = 7,
   parameter int SCORE_BITS  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   dasc_req_if.sink                       req_bus,
   dasc_rsp_if.source                     rsp_bus,
   input  logic                           csr_wr_en,
   input  logic [dasc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dasc_pkg::THRESH_W-1:0]  csr_wdata
);

   // scores are compared at their low SCORE_BITS bits, capped by the port width
   localparam int CMP_BITS = (SCORE_BITS < dasc_pkg::SCORE_W) ? SCORE_BITS : dasc_pkg::SCORE_W;
   // classes beyond the seventh are never scored
   localparam int CLASS_LIMIT = (NUM_CLASSES < dasc_pkg::CLASS_CAP) ? NUM_CLASSES
                                                                     : dasc_pkg::CLASS_CAP;

   logic                         beat_en;
   logic                         merge_go;
   logic [dasc_pkg::CLASS_W-1:0] pos_ff, pos_in;
   logic [dasc_pkg::CLASS_W-1:0] p_idx_now, r_idx_now;

   // frame summary stage
   logic                    sum_valid_ff, sum_valid_in;
   dasc_pkg::frame_sum_type sum_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   dasc_pkg::result_type rsp_res_ff, res_in;

   // merge may run when the result register is empty or being emptied
   assign merge_go      = sum_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !sum_valid_ff || merge_go;
   assign beat_en       = req_bus.valid && req_bus.ready;

   // class position within the frame, saturating, cleared after frame end
   always_comb begin
      pos_in = pos_ff;
      if (beat_en) begin
         if (req_bus.frame_last) begin
            pos_in = '0;
         end else if (pos_ff < dasc_pkg::POS_MAX) begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   dasc_argmax_lane #(
      .CMP_BITS    (CMP_BITS),
      .CLASS_LIMIT (CLASS_LIMIT)
   ) u_lane_primary (
      .clock        (clock),
      .reset        (reset),
      .beat_en      (beat_en),
      .frame_last   (req_bus.frame_last),
      .pos          (pos_ff),
      .score        (req_bus.primary_score),
      .best_idx_now (p_idx_now)
   );

   dasc_argmax_lane #(
      .CMP_BITS    (CMP_BITS),
      .CLASS_LIMIT (CLASS_LIMIT)
   ) u_lane_rotated (
      .clock        (clock),
      .reset        (reset),
      .beat_en      (beat_en),
      .frame_last   (req_bus.frame_last),
      .pos          (pos_ff),
      .score        (req_bus.rotated_score),
      .best_idx_now (r_idx_now)
   );

   // a frame end beat loads the summary; merge drains it
   always_comb begin
      sum_valid_in = sum_valid_ff;
      if (merge_go) begin
         sum_valid_in = 1'b0;
      end
      if (beat_en && req_bus.frame_last) begin
         sum_valid_in = 1'b1;
      end
   end

   dasc_merge #(
      .CLASS_LIMIT (CLASS_LIMIT)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .go        (merge_go),
      .sum       (sum_ff),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .res_in    (res_in)
   );

   // result register: holds a beat until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (merge_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         sum_valid_ff <= sum_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (beat_en && req_bus.frame_last) begin
         sum_ff <= '{primary_idx: p_idx_now, rotated_idx: r_idx_now};
      end
      if (merge_go) begin
         rsp_res_ff <= res_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.stable_class    = rsp_res_ff.stable_class;
   assign rsp_bus.candidate_class = rsp_res_ff.candidate_class;
   assign rsp_bus.switched        = rsp_res_ff.switched;

`ifndef SYNTHESIS
   // a switch leaves candidate and stable equal until a frame with a differing candidate arrives
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.switched |-> rsp_bus.stable_class == rsp_bus.candidate_class)
      else $error("switched set while stable and candidate differ");

   // the stable class is always a scored class
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.stable_class < dasc_pkg::CLASS_W'(CLASS_LIMIT))
      else $error("stable class beyond class limit");

   // a frame end beat restarts the class position
   assert property (@(posedge clock) disable iff (reset)
      beat_en && req_bus.frame_last |=> pos_ff == '0)
      else $error("class position not cleared after frame end");

   // each merge loads the result register, so every frame end beat reaches it
   assert property (@(posedge clock) disable iff (reset)
      merge_go |=> rsp_valid_ff)
      else $error("merge ran without loading a result");
`endif

endmodule

FILE: sv/dasc_argmax_lane.sv
// dasc_argmax_lane: running argmax of one classifier view over a frame
// depends on dasc_pkg

module dasc_argmax_lane #(
   parameter int CMP_BITS    = 16,
   parameter int CLASS_LIMIT = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         beat_en,
   input  logic                         frame_last,
   input  logic [dasc_pkg::CLASS_W-1:0] pos,
   input  logic [dasc_pkg::SCORE_W-1:0] score,
   output logic [dasc_pkg::CLASS_W-1:0] best_idx_now
);

   localparam logic [dasc_pkg::CLASS_W-1:0] LIMIT = dasc_pkg::CLASS_W'(CLASS_LIMIT);

   logic [CMP_BITS-1:0]          best_score_ff, best_score_in, score_now, score_cut;
   logic [dasc_pkg::CLASS_W-1:0] best_idx_ff, best_idx_in;
   logic                         take;

   assign score_cut = score[CMP_BITS-1:0];
   // strict greater-than: earlier class keeps a tie
   assign take      = (pos < LIMIT) && (score_cut > best_score_ff);
   assign score_now    = take ? score_cut : best_score_ff;
   assign best_idx_now = take ? pos : best_idx_ff;

   always_comb begin
      best_score_in = best_score_ff;
      best_idx_in   = best_idx_ff;
      if (beat_en) begin
         if (frame_last) begin
            best_score_in = '0;
            best_idx_in   = '0;
         end else begin
            best_score_in = score_now;
            best_idx_in   = best_idx_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff <= '0;
         best_idx_ff   <= '0;
      end else begin
         best_score_ff <= best_score_in;
         best_idx_ff   <= best_idx_in;
      end
   end

endmodule

FILE: sv/dasc_merge.sv
// dasc_merge: agreement of both lanes, per-class debounce and threshold registers
// depends on dasc_pkg

module dasc_merge #(
   parameter int CLASS_LIMIT = 7
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  dasc_pkg::frame_sum_type        sum,
   input  logic                           csr_wr_en,
   input  logic [dasc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dasc_pkg::THRESH_W-1:0]  csr_wdata,
   output dasc_pkg::result_type           res_in
);

   localparam logic [dasc_pkg::CLASS_W-1:0] LIMIT = dasc_pkg::CLASS_W'(CLASS_LIMIT);
   localparam logic [dasc_pkg::CSR_IDX_W-1:0] REG_COUNT =
      dasc_pkg::CSR_IDX_W'(dasc_pkg::NUM_REGS);

   dasc_pkg::thresh_array_type   thresh_ff;
   dasc_pkg::thresh_array_type   cnt_ff, cnt_in;
   logic [dasc_pkg::CLASS_W-1:0] cand_ff, cand_in, stable_ff, stable_in;
   logic                         sw_ff, sw_in;

   always_comb begin
      cand_in   = cand_ff;
      stable_in = stable_ff;
      sw_in     = sw_ff;
      cnt_in    = cnt_ff;
      if (go) begin
         if (sum.primary_idx == sum.rotated_idx) begin
            cand_in = sum.primary_idx;
         end
         if ((cand_in < LIMIT) && (cand_in != stable_ff)) begin
            if (cnt_ff[cand_in] < thresh_ff[cand_in]) begin
               cnt_in[cand_in] = cnt_ff[cand_in] + 8'd1;
               sw_in           = 1'b0;
            end else begin
               stable_in = cand_in;
               sw_in     = 1'b1;
               for (int i = 0; i < dasc_pkg::NUM_REGS; i++) begin
                  cnt_in[i] = '0;
               end
            end
         end
      end
   end

   assign res_in = '{stable_class: stable_in, candidate_class: cand_in, switched: sw_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff   <= '0;
         stable_ff <= '0;
         sw_ff     <= 1'b0;
         for (int i = 0; i < dasc_pkg::NUM_REGS; i++) begin
            cnt_ff[i]    <= '0;
            thresh_ff[i] <= dasc_pkg::THRESH_RESET;
         end
      end else begin
         cand_ff   <= cand_in;
         stable_ff <= stable_in;
         sw_ff     <= sw_in;
         cnt_ff    <= cnt_in;
         if (csr_wr_en && (csr_index < REG_COUNT)) begin
            thresh_ff[csr_index] <= csr_wdata;
         end
      end
   end

endmodule
